/* sv/usd_pkg.sv */
// Shared types, constants and helper functions of the UTF-8 stream decoder.
`timescale 1ns / 1ps

package usd_pkg;

    // Replacement character for any invalid or truncated sequence
    localparam logic [20:0] REPL_CP    = 21'h00FFFD;

    // Lead byte thresholds
    localparam logic [7:0]  LEAD_TWO   = 8'hC0;
    localparam logic [7:0]  LEAD_THREE = 8'hE0;
    localparam logic [7:0]  LEAD_FOUR  = 8'hF0;
    localparam logic [7:0]  ASCII_END  = 8'h80;

    // Continuation byte tag (top two bits)
    localparam logic [1:0]  CONT_TAG   = 2'b10;

    // Overlong, surrogate and range limits
    localparam logic [10:0] MIN_TWO    = 11'h080;
    localparam logic [15:0] MIN_THREE  = 16'h0800;
    localparam logic [15:0] SURR_LO    = 16'hD800;
    localparam logic [15:0] SURR_HI    = 16'hDFFF;
    localparam logic [21:0] MIN_FOUR   = 22'h010000;
    localparam logic [21:0] MAX_CP     = 22'h10FFFF;

    // Commands from controller to datapath
    typedef struct packed {
        logic load;   // capture the incoming word into the byte buffer
        logic emit;   // retire one sequence into the output register
    } usd_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic hold;      // head sequence is incomplete and the stream goes on
        logic last;      // the result about to be emitted ends this word's run
        logic out_free;  // output register can take a result this cycle
    } usd_status_t;

    // Bytes needed by a sequence starting with lead byte b
    function automatic logic [2:0] seq_need(input logic [7:0] b);
        logic [2:0] n;
        priority if (b < LEAD_TWO)
            n = 3'd1;
        else if (b < LEAD_THREE)
            n = 3'd2;
        else if (b < LEAD_FOUR)
            n = 3'd3;
        else
            n = 3'd4;
        return n;
    endfunction

endpackage

/* sv/usd_in_if.sv */
// Input channel of the UTF-8 stream decoder: one raw byte per word.
`timescale 1ns / 1ps

interface usd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_value;
    logic       stream_end;

    modport source (output valid, output byte_value, output stream_end, input ready);
    modport sink   (input valid, input byte_value, input stream_end, output ready);
endinterface

/* sv/usd_out_if.sv */
// Output channel of the UTF-8 stream decoder: one code point per word.
`timescale 1ns / 1ps

interface usd_out_if;
    logic        valid;
    logic        ready;
    logic [20:0] code_point;
    logic        replaced;
    logic [2:0]  seq_length;
    logic        run_final;

    modport source (output valid, output code_point, output replaced,
                    output seq_length, output run_final, input ready);
    modport sink   (input valid, input code_point, input replaced,
                    input seq_length, input run_final, output ready);
endinterface

/* sv/utf8_stream_decoder.sv */
// Top level of the UTF-8 stream decoder with U+FFFD replacement.
`timescale 1ns / 1ps

// Takes a UTF-8 byte stream, one byte per word on the utf8 channel with a
// stream_end flag on the final byte, and returns one code point per word on
// the points channel. Leads C0-DF, E0-EF and F0-FF open sequences of two,
// three and four bytes (F8-FF always fail). Bad continuation bytes, overlong
// forms, surrogates, values above 10FFFF, stray continuation bytes and
// sequences cut short by stream_end each yield U+FFFD with replaced set; only
// the lead byte is consumed and the bytes after it are decoded again. Up to
// three bytes are held between words. run_final marks the last code point
// caused by an input word; a word that only extends a held sequence causes
// none. Sequencing: a word is loaded into the buffer, then the single decode
// unit retires one sequence per cycle while the points channel keeps up, so a
// word yields N results (N from 0 to 4); back-pressure there stalls the
// retiring. The next word is taken as soon as the last result has entered the
// output register, while it still waits to be taken, or as soon as the head
// is found to need more bytes.
module utf8_stream_decoder
    import usd_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    usd_in_if.sink    utf8,
    usd_out_if.source points
);

    usd_cmd_t    cmd;
    usd_status_t status;

    // Sequencing: load a word, then retire sequences until the run ends
    usd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (utf8.valid),
        .in_ready (utf8.ready),
        .status   (status),
        .cmd      (cmd)
    );

    // Buffer, validity checks and output register
    usd_datapath u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .status     (status),
        .byte_value (utf8.byte_value),
        .stream_end (utf8.stream_end),
        .out_valid  (points.valid),
        .out_ready  (points.ready),
        .code_point (points.code_point),
        .replaced   (points.replaced),
        .seq_length (points.seq_length),
        .run_final  (points.run_final)
    );

endmodule

/* sv/usd_ctrl.sv */
// Controller state machine of the UTF-8 stream decoder.
`timescale 1ns / 1ps

module usd_ctrl
    import usd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  usd_status_t status,
    output usd_cmd_t    cmd
);

    typedef enum logic [1:0] {
        ST_IDLE   = 2'b01,
        ST_DECODE = 2'b10
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                // Drop back to idle when the head needs more bytes
                if (status.hold)
                    state_next = ST_IDLE;
                else if (status.out_free)
                begin
                    cmd.emit = 1'b1;
                    if (status.last)
                        state_next = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

/* sv/usd_datapath.sv */
// Datapath of the UTF-8 stream decoder: byte buffer, sequence check, output register.
`timescale 1ns / 1ps

module usd_datapath
    import usd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  usd_cmd_t    cmd,
    output usd_status_t status,
    input  logic [7:0]  byte_value,
    input  logic        stream_end,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [20:0] code_point,
    output logic        replaced,
    output logic [2:0]  seq_length,
    output logic        run_final
);

    // Byte buffer: held bytes plus the newest word, head always at entry 0
    logic [7:0]  buf_reg  [4];
    logic [7:0]  buf_next [4];
    logic [2:0]  count_reg, count_next;
    logic        end_reg, end_next;

    logic        out_valid_reg, out_valid_next;
    logic [20:0] code_point_reg;
    logic        replaced_reg;
    logic [2:0]  seq_length_reg;
    logic        run_final_reg;

    logic [2:0]  need;
    logic        enough;
    logic        cont1, cont2, cont3;
    logic [10:0] v2;
    logic [15:0] v3;
    logic [21:0] v4;
    logic        full_ok;
    logic [20:0] cp_full;
    logic        bad;
    logic [2:0]  used;
    logic [2:0]  count_after;
    logic [2:0]  need_next;
    logic        last;

    assign need   = seq_need(buf_reg[0]);
    assign enough = (count_reg >= need);
    assign cont1  = (buf_reg[1][7:6] == CONT_TAG);
    assign cont2  = (buf_reg[2][7:6] == CONT_TAG);
    assign cont3  = (buf_reg[3][7:6] == CONT_TAG);

    assign v2 = {buf_reg[0][4:0], buf_reg[1][5:0]};
    assign v3 = {buf_reg[0][3:0], buf_reg[1][5:0], buf_reg[2][5:0]};
    assign v4 = {buf_reg[0][3:0], buf_reg[1][5:0], buf_reg[2][5:0], buf_reg[3][5:0]};

    // Check a complete sequence at the head
    always_comb
    begin
        unique case (need)
            3'd1:
            begin
                full_ok = (buf_reg[0] < ASCII_END);
                cp_full = {13'd0, buf_reg[0]};
            end
            3'd2:
            begin
                full_ok = cont1 && (v2 >= MIN_TWO);
                cp_full = {10'd0, v2};
            end
            3'd3:
            begin
                full_ok = cont1 && cont2 && (v3 >= MIN_THREE)
                          && ((v3 < SURR_LO) || (v3 > SURR_HI));
                cp_full = {5'd0, v3};
            end
            default:
            begin
                full_ok = cont1 && cont2 && cont3 && (v4 >= MIN_FOUR) && (v4 <= MAX_CP);
                cp_full = v4[20:0];
            end
        endcase
    end

    // A truncated head is only reached at stream end; otherwise it holds
    assign bad         = !enough || !full_ok;
    assign used        = bad ? 3'd1 : need;
    assign count_after = count_reg - used;
    assign need_next   = seq_need(buf_reg[used[1:0]]);
    assign last        = (count_after == 3'd0) || (!end_reg && (count_after < need_next));

    assign status.hold     = !enough && !end_reg;
    assign status.last     = last;
    assign status.out_free = !out_valid_reg || out_ready;

    // Buffer update: load at the tail, or advance the head by the bytes used
    always_comb
    begin
        logic [2:0] idx;
        idx        = 3'd0;
        buf_next   = buf_reg;
        count_next = count_reg;
        end_next   = end_reg;
        if (cmd.load)
        begin
            buf_next[count_reg[1:0]] = byte_value;
            count_next               = count_reg + 3'd1;
            end_next                 = stream_end;
        end
        else if (cmd.emit)
        begin
            for (int i = 0; i < 4; i++)
            begin
                idx = 3'(i) + used;
                if (idx < 3'd4)
                    buf_next[i] = buf_reg[idx[1:0]];
            end
            count_next = count_after;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.emit)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= 3'd0;
            end_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            end_reg       <= end_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        buf_reg <= buf_next;
        if (cmd.emit)
        begin
            code_point_reg <= bad ? REPL_CP : cp_full;
            replaced_reg   <= bad;
            seq_length_reg <= used;
            run_final_reg  <= last;
        end
    end

    assign out_valid  = out_valid_reg;
    assign code_point = code_point_reg;
    assign replaced   = replaced_reg;
    assign seq_length = seq_length_reg;
    assign run_final  = run_final_reg;

    // Every retired sequence consumes at least one buffered byte
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |=> (count_reg < $past(count_reg)))
        else $error("emit did not consume buffered bytes");

    // No more than three bytes are ever held when a word arrives
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |-> (count_reg <= 3'd3))
        else $error("byte buffer overflow on load");

    // A replacement always stands for exactly one byte
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && replaced_reg) |-> ((seq_length_reg == 3'd1)
                                             && (code_point_reg == REPL_CP)))
        else $error("replacement with wrong length or value");

    // At stream end the last result leaves the buffer empty
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit && last && end_reg) |=> (count_reg == 3'd0))
        else $error("bytes left over after end of stream");

endmodule

/* dv/usd_point_checker.sv */
// Checker for the UTF-8 stream decoder: predicts code points per byte and compares.
`timescale 1ns / 1ps

module usd_point_checker (
    input  logic clk,
    input  logic rst_n,
    usd_in_if    utf8,
    usd_out_if   points,
    output int   fail_n,
    output int   owed_n,
    output int   points_n,
    output int   repl_n
);

    localparam logic [20:0] REPLACEMENT   = 21'h00FFFD;
    localparam logic [21:0] TWO_BYTE_MIN  = 22'h000080;
    localparam logic [21:0] THREE_BYTE_MIN = 22'h000800;
    localparam logic [21:0] SURROGATE_LO  = 22'h00D800;
    localparam logic [21:0] SURROGATE_HI  = 22'h00DFFF;
    localparam logic [21:0] FOUR_BYTE_MIN = 22'h010000;
    localparam logic [21:0] UNICODE_MAX   = 22'h10FFFF;

    typedef logic [7:0] octet_t;

    typedef struct packed {
        logic [20:0] cp;
        logic        repl;
        logic [2:0]  len;
        logic        fin;
    } point_t;

    point_t      points_owed [$];
    octet_t      held [3];
    int unsigned held_n;

    function automatic int unsigned lead_len(input octet_t b);
        if (b < 8'hC0)
            return 1;
        if (b < 8'hE0)
            return 2;
        if (b < 8'hF0)
            return 3;
        return 4;
    endfunction

    // Decode a complete sequence of need bytes starting at win[at]; true when valid.
    function automatic logic decode_at(input octet_t win [4], input int unsigned at,
                                       input int unsigned need, output logic [20:0] cp);
        logic [21:0] v;
        logic        conts;
        logic        ok;
        int unsigned k;
        conts = 1'b1;
        for (k = 1; k < need; k++)
            conts &= (win[at + k][7:6] == 2'b10);
        case (need)
            1:
            begin
                v  = {14'd0, win[at]};
                ok = win[at] < 8'h80;
            end
            2:
            begin
                v  = {11'd0, win[at][4:0], win[at + 1][5:0]};
                ok = conts && v >= TWO_BYTE_MIN;
            end
            3:
            begin
                v  = {6'd0, win[at][3:0], win[at + 1][5:0], win[at + 2][5:0]};
                ok = conts && v >= THREE_BYTE_MIN && (v < SURROGATE_LO || v > SURROGATE_HI);
            end
            default:
            begin
                v  = {win[at][3:0], win[at + 1][5:0], win[at + 2][5:0], win[at + 3][5:0]};
                ok = conts && v >= FOUR_BYTE_MIN && v <= UNICODE_MAX;
            end
        endcase
        cp = v[20:0];
        return ok;
    endfunction

    // Append the held bytes and the new byte, retire every sequence that can be
    // settled now, and keep the rest for later words.
    task automatic decode_word(input octet_t b, input logic last);
        octet_t      win [4];
        point_t      run [4];
        int unsigned n;
        int unsigned head;
        int unsigned need;
        int unsigned nres;
        int unsigned i;
        logic        ok;
        logic [20:0] cp;
        n = held_n;
        for (i = 0; i < n; i++)
            win[i] = held[i];
        win[n] = b;
        n++;
        head = 0;
        nres = 0;
        while (head < n) begin
            need = lead_len(win[head]);
            cp   = '0;
            if (n - head < need) begin
                if (!last)
                    break;
                ok = 1'b0;
            end
            else
                ok = decode_at(win, head, need, cp);
            if (ok) begin
                run[nres] = '{cp, 1'b0, 3'(need), 1'b0};
                head += need;
            end
            else begin
                run[nres] = '{REPLACEMENT, 1'b1, 3'd1, 1'b0};
                head += 1;
            end
            nres++;
        end
        if (nres > 0)
            run[nres - 1].fin = 1'b1;
        for (i = 0; i < nres; i++)
            points_owed.push_back(run[i]);
        held_n = n - head;
        for (i = 0; i < held_n; i++)
            held[i] = win[head + i];
    endtask

    task automatic report_miss(input string what);
        fail_n++;
        $display("[%0t] checker: %s", $time, what);
    endtask

    task automatic check_point();
        point_t want;
        points_n++;
        if (points.replaced === 1'b1)
            repl_n++;
        if (points_owed.size() == 0) begin
            report_miss($sformatf("code point %h arrived with none owed", points.code_point));
            return;
        end
        want = points_owed.pop_front();
        if (points.code_point !== want.cp)
            report_miss($sformatf("code_point %h, want %h", points.code_point, want.cp));
        if (points.replaced !== want.repl)
            report_miss($sformatf("replaced %b, want %b (cp %h)",
                                  points.replaced, want.repl, want.cp));
        if (points.seq_length !== want.len)
            report_miss($sformatf("seq_length %0d, want %0d (cp %h)",
                                  points.seq_length, want.len, want.cp));
        if (points.run_final !== want.fin)
            report_miss($sformatf("run_final %b, want %b (cp %h)",
                                  points.run_final, want.fin, want.cp));
    endtask

    // Results are registered and never leave in the same cycle as their word, so check before predicting.
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            held_n   = 0;
            fail_n   = 0;
            points_n = 0;
            repl_n   = 0;
            points_owed.delete();
            owed_n <= 0;
        end
        else begin
            if (points.valid === 1'b1 && points.ready === 1'b1)
                check_point();
            if (utf8.valid === 1'b1 && utf8.ready === 1'b1)
                decode_word(utf8.byte_value, utf8.stream_end);
            owed_n <= points_owed.size();
        end
    end

endmodule

/* dv/tb.sv */
// Testbench top for the UTF-8 stream decoder: byte stimulus, output pacing and verdict.
`timescale 1ns / 1ps

// The decoder takes one byte per word and returns zero to four code points
// per word. Stimulus here is a short list of hand-picked edge cases, then
// random chunks: mostly well-formed UTF-8 with random code points, the rest
// cut-short, corrupted, overlong, surrogate, out-of-range and plain noise.
// The checker beside the block predicts every code point and compares; this
// module only paces both channels and gives the verdict.
module tb;

    typedef enum logic [1:0] {RX_RANDOM, RX_FREE, RX_HOLD} rx_mode_t;

    localparam int IDLE_PCT      = 31;
    localparam int HOLD_CYCLES   = 300;
    localparam int CALM_WORDS    = 120;
    localparam int HOLD_WORDS    = 40;
    localparam int PAUSE_AT      = 250;
    localparam int RANDOM_WORDS  = 360;
    localparam int DRAIN_CYCLES  = 20;
    localparam int EDGE_COUNT    = 24;

    // Hand-picked words, {stream_end, byte}
    localparam logic [8:0] EDGE_WORDS [EDGE_COUNT] = '{
        9'h07F,                          // top of ASCII
        9'h0BF,                          // stray continuation byte
        9'h0C0, 9'h080,                  // overlong two-byte form
        9'h0DF, 9'h0BF,                  // U+07FF, largest two-byte value
        9'h0C3, 9'h041,                  // bad continuation, then 'A' decoded again
        9'h0ED, 9'h0A0, 9'h080,          // surrogate
        9'h0F4, 9'h090, 9'h080, 9'h080,  // above U+10FFFF: four results on one word
        9'h0F4, 9'h08F, 9'h0BF, 9'h0BF,  // U+10FFFF
        9'h0FF, 9'h100,                  // F8-FF lead cut short by the stream end
        9'h0E2, 9'h182,                  // three-byte sequence cut short by the end
        9'h100                           // NUL as the last byte of a stream
    };

    localparam logic [20:0] EDGE_POINTS [10] = '{
        21'h000000, 21'h00007F, 21'h000080, 21'h0007FF, 21'h000800,
        21'h00D7FF, 21'h00E000, 21'h00FFFF, 21'h010000, 21'h10FFFF
    };

    logic     clk;
    logic     rst_n;
    rx_mode_t rx_mode = RX_RANDOM;
    logic     tx_calm = 1'b0;
    int       words_sent = 0;
    int       fail_n;
    int       owed_n;
    int       points_n;
    int       repl_n;

    // Pending chunk of words, {stream_end, byte}
    logic [8:0] chunk_q [$];

    usd_in_if  utf8 ();
    usd_out_if points ();

    utf8_stream_decoder DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .utf8   (utf8),
        .points (points)
    );

    usd_point_checker point_chk (
        .clk      (clk),
        .rst_n    (rst_n),
        .utf8     (utf8),
        .points   (points),
        .fail_n   (fail_n),
        .owed_n   (owed_n),
        .points_n (points_n),
        .repl_n   (repl_n)
    );

    initial clk = 1'b0;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Hard stop: far beyond the slowest legal run.
    initial
    begin
        #5_000_000;
        $display("tb: done, errors");
        $finish;
    end

    // Receiver pacing. In hold mode, keep ready low for a long stretch counted
    // here, then fall back to random pacing until the mode changes.
    initial
    begin
        int unsigned held_off;
        held_off = 0;
        points.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (rx_mode == RX_HOLD && held_off < HOLD_CYCLES) begin
                points.ready <= 1'b0;
                held_off++;
            end
            else begin
                if (rx_mode != RX_HOLD)
                    held_off = 0;
                points.ready <= (rx_mode == RX_FREE) || ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    // Offer one word and hold it until accepted. A random idle gap may go before
    // the word (never with tx_calm), so the step of acceptance never assigns valid twice.
    task automatic send_word(input logic [7:0] b, input logic last);
        if (!tx_calm && $urandom_range(99) < IDLE_PCT) begin
            utf8.valid      <= 1'b0;
            utf8.byte_value <= 8'($urandom);
            utf8.stream_end <= 1'($urandom);
            do
                @(posedge clk);
            while ($urandom_range(99) < IDLE_PCT);
        end
        utf8.valid      <= 1'b1;
        utf8.byte_value <= b;
        utf8.stream_end <= last;
        do
            @(posedge clk);
        while (utf8.ready !== 1'b1);
        words_sent++;
    endtask

    // Drop valid in the step of the last acceptance and wait for every owed result.
    task automatic drain_points();
        utf8.valid <= 1'b0;
        do
            @(posedge clk);
        while (owed_n != 0);
    endtask

    function automatic int unsigned utf8_len(input logic [20:0] cp);
        if (cp < 21'h80)
            return 1;
        if (cp < 21'h800)
            return 2;
        if (cp < 21'h10000)
            return 3;
        return 4;
    endfunction

    // Encode v in exactly n bytes; a short v gives an overlong form.
    function automatic void push_utf8(input logic [20:0] v, input int unsigned n);
        case (n)
            1:
                chunk_q.push_back({2'b00, v[6:0]});
            2:
            begin
                chunk_q.push_back({1'b0, 3'b110, v[10:6]});
                chunk_q.push_back({1'b0, 2'b10, v[5:0]});
            end
            3:
            begin
                chunk_q.push_back({1'b0, 4'b1110, v[15:12]});
                chunk_q.push_back({1'b0, 2'b10, v[11:6]});
                chunk_q.push_back({1'b0, 2'b10, v[5:0]});
            end
            default:
            begin
                chunk_q.push_back({1'b0, 5'b11110, v[20:18]});
                chunk_q.push_back({1'b0, 2'b10, v[17:12]});
                chunk_q.push_back({1'b0, 2'b10, v[11:6]});
                chunk_q.push_back({1'b0, 2'b10, v[5:0]});
            end
        endcase
    endfunction

    // Valid code point: sometimes a class boundary, otherwise any length class.
    function automatic logic [20:0] pick_point();
        logic [20:0] cp;
        if ($urandom_range(9) == 0)
            return EDGE_POINTS[$urandom_range(9)];
        case ($urandom_range(3))
            0:       cp = 21'($urandom_range(32'h7F, 32'h0));
            1:       cp = 21'($urandom_range(32'h7FF, 32'h80));
            2:       cp = 21'($urandom_range(32'hFFFF, 32'h800));
            default: cp = 21'($urandom_range(32'h10FFFF, 32'h10000));
        endcase
        // fold surrogates up into F800-FFFF
        if (cp >= 21'hD800 && cp <= 21'hDFFF)
            cp ^= 21'h2000;
        return cp;
    endfunction

    // Build one random chunk: mostly well-formed text, the rest broken forms.
    task automatic build_chunk();
        int unsigned kind;
        int unsigned n;
        int unsigned k;
        logic [20:0] cp;
        logic [1:0]  tag;
        chunk_q.delete();
        kind = $urandom_range(99);
        if (kind < 70) begin
            repeat ($urandom_range(4, 1)) begin
                cp = pick_point();
                push_utf8(cp, utf8_len(cp));
            end
        end
        else if (kind < 78) begin
            // cut short, often right at the end of the stream
            cp = 21'($urandom_range(32'h10FFFF, 32'h80));
            n  = utf8_len(cp);
            push_utf8(cp, n);
            k  = $urandom_range(n - 1, 1);
            repeat (n - k)
                void'(chunk_q.pop_back());
            if ($urandom_range(1) == 1)
                chunk_q[chunk_q.size() - 1][8] = 1'b1;
        end
        else if (kind < 86) begin
            // one continuation byte without its 10 tag
            cp = 21'($urandom_range(32'h10FFFF, 32'h80));
            n  = utf8_len(cp);
            push_utf8(cp, n);
            k   = $urandom_range(n - 1, 1);
            tag = 2'($urandom_range(2));
            if (tag == 2'b10)
                tag = 2'b11;
            chunk_q[k][7:6] = tag;
        end
        else if (kind < 93) begin
            case ($urandom_range(3))
                0:
                begin
                    // overlong
                    n = $urandom_range(4, 2);
                    case (n)
                        2:       cp = 21'($urandom_range(32'h7F, 32'h0));
                        3:       cp = 21'($urandom_range(32'h7FF, 32'h0));
                        default: cp = 21'($urandom_range(32'hFFFF, 32'h0));
                    endcase
                    push_utf8(cp, n);
                end
                1:
                    push_utf8(21'($urandom_range(32'hDFFF, 32'hD800)), 3);
                2:
                    push_utf8(21'($urandom_range(32'h1FFFFF, 32'h110000)), 4);
                default:
                begin
                    chunk_q.push_back({1'b0, 5'b11111, 3'($urandom)});
                    repeat (3)
                        chunk_q.push_back({1'b0, 2'b10, 6'($urandom)});
                end
            endcase
        end
        else begin
            repeat ($urandom_range(3, 1))
                chunk_q.push_back({1'b0, 8'($urandom)});
        end
        // scatter stream ends anywhere
        foreach (chunk_q[i])
            if ($urandom_range(49) == 0)
                chunk_q[i][8] = 1'b1;
    endtask

    task automatic send_chunk();
        build_chunk();
        foreach (chunk_q[i])
            send_word(chunk_q[i][7:0], chunk_q[i][8]);
    endtask

    initial
    begin
        int hold_start;
        logic paused;
        paused = 1'b0;
        utf8.valid      <= 1'b0;
        utf8.byte_value <= 8'h00;
        utf8.stream_end <= 1'b0;
        rst_n           <= 1'b0;
        repeat (7)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Edge cases with random pacing on both sides.
        for (int i = 0; i < EDGE_COUNT; i++)
            send_word(EDGE_WORDS[i][7:0], EDGE_WORDS[i][8]);
        drain_points();

        // A stretch with no idling on either side.
        tx_calm = 1'b1;
        rx_mode <= RX_FREE;
        while (words_sent < EDGE_COUNT + CALM_WORDS)
            send_chunk();

        // Hold the receiver off while the sender keeps offering; the block
        // fills and must stall its input without losing a word.
        rx_mode <= RX_HOLD;
        hold_start = words_sent;
        while (words_sent < hold_start + HOLD_WORDS)
            send_chunk();

        // Random pacing for the rest, with one full pause midway.
        rx_mode <= RX_RANDOM;
        tx_calm = 1'b0;
        while (words_sent < EDGE_COUNT + RANDOM_WORDS) begin
            send_chunk();
            if (!paused && words_sent >= EDGE_COUNT + PAUSE_AT) begin
                paused = 1'b1;
                drain_points();
            end
        end

        drain_points();
        repeat (DRAIN_CYCLES)
            @(posedge clk);

        $display("run: %0d bytes in, %0d code points checked, %0d of them U+FFFD",
                 words_sent, points_n, repl_n);
        $display("run: edge cases, valid and broken UTF-8, stream ends, output stall, pauses");
        if (fail_n == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

endmodule
